[hw/rtl/pmct_pkg.sv]
// Shared types and constants for the PS/2 mouse cursor tracker.
`timescale 1ns / 1ps
`default_nettype none

package pmct_pkg;

	// Position width default and configuration register width
	localparam int PosWidthDefault = 10;
	localparam int CfgWidth        = 10;
	localparam int ByteWidth       = 8;
	localparam int OutPosWidth     = 10;

	// APB register file geometry
	localparam int ApbDataWidth  = 32;
	localparam int ApbAddrWidth  = 3;
	localparam int RegIndexWidth = 1;

	// Register indexes
	localparam logic [RegIndexWidth-1:0] RegXMax = 1'b0;
	localparam logic [RegIndexWidth-1:0] RegYMax = 1'b1;

	// Reset values
	localparam logic [CfgWidth-1:0] XMaxReset = 10'd640;
	localparam logic [CfgWidth-1:0] YMaxReset = 10'd480;
	localparam int PosXReset = 320;
	localparam int PosYReset = 240;

	// Header byte bit positions
	localparam int BitLeft  = 0;
	localparam int BitRight = 1;
	localparam int BitXSign = 4;
	localparam int BitYSign = 5;

	// Byte place inside a three-byte packet
	typedef enum logic [1:0] {
		PhaseHeader = 2'd0,
		PhaseX      = 2'd1,
		PhaseY      = 2'd2
	} phase_t;

	// Cursor limits from the register file
	typedef struct packed {
		logic [CfgWidth-1:0] x_max;
		logic [CfgWidth-1:0] y_max;
	} cfg_t;

endpackage

`default_nettype wire

[hw/rtl/pmct_cfg_regs.sv]
// APB register file holding the cursor limits.
`timescale 1ns / 1ps
`default_nettype none

module pmct_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [pmct_pkg::ApbAddrWidth-1:0]  paddr,
	input  wire logic [pmct_pkg::ApbDataWidth-1:0]  pwdata,
	output logic      [pmct_pkg::ApbDataWidth-1:0]  prdata,
	output logic                                    pready,
	output pmct_pkg::cfg_t                          cfg
);
	import pmct_pkg::*;

	logic [CfgWidth-1:0]      x_max_q;
	logic [CfgWidth-1:0]      y_max_q;
	logic [RegIndexWidth-1:0] reg_index;
	logic                     wr_en;

	assign reg_index = paddr[ApbAddrWidth-1:ApbAddrWidth-RegIndexWidth];
	assign wr_en     = psel && penable && pwrite;
	assign pready    = 1'b1;

	// Write the addressed limit on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_max_q <= XMaxReset;
			y_max_q <= YMaxReset;
		end else if (wr_en) begin
			unique case (reg_index)
				RegXMax: x_max_q <= pwdata[CfgWidth-1:0];
				RegYMax: y_max_q <= pwdata[CfgWidth-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed limit
	always_comb begin
		unique case (reg_index)
			RegXMax: prdata = ApbDataWidth'(x_max_q);
			RegYMax: prdata = ApbDataWidth'(y_max_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.x_max = x_max_q;
	assign cfg.y_max = y_max_q;

endmodule

`default_nettype wire

[hw/rtl/pmct_axis.sv]
// Saturating cursor move along one axis by a 9-bit signed delta.
`timescale 1ns / 1ps
`default_nettype none

module pmct_axis #(
	parameter int POS_WIDTH = pmct_pkg::PosWidthDefault
) (
	input  wire logic [POS_WIDTH-1:0]             pos,
	input  wire logic [pmct_pkg::ByteWidth-1:0]   delta_byte,
	input  wire logic                             negative,
	input  wire logic [pmct_pkg::CfgWidth-1:0]    limit,
	output logic      [POS_WIDTH-1:0]             moved
);
	import pmct_pkg::*;

	localparam int SumWidth = ((POS_WIDTH > CfgWidth) ? POS_WIDTH : CfgWidth) + 1;
	localparam logic [SumWidth-1:0] PosMask = SumWidth'((1 << POS_WIDTH) - 1);

	logic [ByteWidth:0]   magnitude;
	logic [SumWidth-1:0]  pos_ext;
	logic [SumWidth-1:0]  limit_ext;
	logic [SumWidth-1:0]  ceiling;
	logic [SumWidth-1:0]  sum;

	// Clamp the limit to what the position can hold
	assign pos_ext   = SumWidth'(pos);
	assign limit_ext = SumWidth'(limit);
	assign ceiling   = (limit_ext > PosMask) ? PosMask : limit_ext;

	// Negative delta magnitude is 256 minus the byte
	assign magnitude = (ByteWidth+1)'(9'd256 - {1'b0, delta_byte});
	assign sum       = pos_ext + SumWidth'(delta_byte);

	// Floor at zero going down, saturate at the ceiling going up
	always_comb begin
		if (negative) begin
			if (pos_ext < SumWidth'(magnitude))
				moved = '0;
			else
				moved = POS_WIDTH'(pos_ext - SumWidth'(magnitude));
		end else if (sum > ceiling) begin
			moved = ceiling[POS_WIDTH-1:0];
		end else begin
			moved = sum[POS_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ps2_mouse_cursor_tracker_core.sv]
// PS/2 mouse cursor tracker: packet phase, button and cursor state, result register.
// The result register takes each accepted byte's result beat; the single shared
// saturating adder sets the cycle path; one byte per cycle unless stalled.
// packet_ready stays high while the result register is empty or being drained this cycle.
// Reset: asynchronous, active low; cursor at (320, 240), buttons and signs clear,
// phase at header, limits at (640, 480), result register empty.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_cursor_tracker_core #(
	parameter int POS_WIDTH = pmct_pkg::PosWidthDefault
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [pmct_pkg::ApbAddrWidth-1:0]   paddr,
	input  wire logic [pmct_pkg::ApbDataWidth-1:0]   pwdata,
	output logic      [pmct_pkg::ApbDataWidth-1:0]   prdata,
	output logic                                     pready,
	// byte channel
	input  wire logic                                packet_valid,
	output logic                                     packet_ready,
	input  wire logic [pmct_pkg::ByteWidth-1:0]      packet_byte,
	// result channel
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output logic                                     left_button,
	output logic                                     right_button,
	output logic      [pmct_pkg::OutPosWidth-1:0]    cursor_x,
	output logic      [pmct_pkg::OutPosWidth-1:0]    cursor_y,
	output logic      [1:0]                          byte_phase,
	output logic                                     packet_done
);
	import pmct_pkg::*;

	localparam int ExtWidth = (POS_WIDTH > OutPosWidth) ? POS_WIDTH : OutPosWidth;
	localparam logic [POS_WIDTH-1:0] PosXInit = POS_WIDTH'(PosXReset);
	localparam logic [POS_WIDTH-1:0] PosYInit = POS_WIDTH'(PosYReset);

	cfg_t cfg;

	// Tracker state
	phase_t                 phase_q;
	phase_t                 phase_next;
	logic                   left_held_q;
	logic                   right_held_q;
	logic                   x_negative_q;
	logic                   y_negative_q;
	logic [POS_WIDTH-1:0]   pos_x_q;
	logic [POS_WIDTH-1:0]   pos_y_q;

	// Result register
	logic                   result_valid_q;
	logic                   left_button_q;
	logic                   right_button_q;
	logic [OutPosWidth-1:0] cursor_x_q;
	logic [OutPosWidth-1:0] cursor_y_q;
	logic [1:0]             byte_phase_q;
	logic                   packet_done_q;

	// Decoded per-byte actions
	logic                   is_header;
	logic                   is_x;
	logic                   is_y;
	phase_t                 phase_out;

	logic                   accept;
	logic [POS_WIDTH-1:0]   axis_pos;
	logic                   axis_negative;
	logic [CfgWidth-1:0]    axis_limit;
	logic [POS_WIDTH-1:0]   axis_moved;

	logic                   left_next;
	logic                   right_next;
	logic                   x_negative_next;
	logic                   y_negative_next;
	logic [POS_WIDTH-1:0]   pos_x_next;
	logic [POS_WIDTH-1:0]   pos_y_next;
	logic [ExtWidth-1:0]    pos_x_ext;
	logic [ExtWidth-1:0]    pos_y_ext;

	pmct_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Take a byte whenever the result register is free or draining
	assign packet_ready = !result_valid_q || result_ready;
	assign accept       = packet_valid && packet_ready;

	// Advance the packet phase
	always_comb begin
		unique case (phase_q)
			PhaseX:  phase_next = PhaseY;
			PhaseY:  phase_next = PhaseHeader;
			default: phase_next = PhaseX;
		endcase
	end

	// Decode what this byte updates
	always_comb begin
		is_header = 1'b0;
		is_x      = 1'b0;
		is_y      = 1'b0;
		unique case (phase_q)
			PhaseX: begin
				is_x      = 1'b1;
				phase_out = PhaseX;
			end
			PhaseY: begin
				is_y      = 1'b1;
				phase_out = PhaseY;
			end
			default: begin
				is_header = 1'b1;
				phase_out = PhaseHeader;
			end
		endcase
	end

	// Share one saturating adder between the two axes
	assign axis_pos      = is_y ? pos_y_q      : pos_x_q;
	assign axis_negative = is_y ? y_negative_q : x_negative_q;
	assign axis_limit    = is_y ? cfg.y_max    : cfg.x_max;

	pmct_axis #(
		.POS_WIDTH (POS_WIDTH)
	) u_axis (
		.pos        (axis_pos),
		.delta_byte (packet_byte),
		.negative   (axis_negative),
		.limit      (axis_limit),
		.moved      (axis_moved)
	);

	// Next state after this byte
	assign left_next       = is_header ? packet_byte[BitLeft]  : left_held_q;
	assign right_next      = is_header ? packet_byte[BitRight] : right_held_q;
	assign x_negative_next = is_header ? packet_byte[BitXSign] : x_negative_q;
	assign y_negative_next = is_header ? packet_byte[BitYSign] : y_negative_q;
	assign pos_x_next      = is_x ? axis_moved : pos_x_q;
	assign pos_y_next      = is_y ? axis_moved : pos_y_q;
	assign pos_x_ext       = ExtWidth'(pos_x_next);
	assign pos_y_ext       = ExtWidth'(pos_y_next);

	// Update tracker state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PhaseHeader;
			left_held_q  <= 1'b0;
			right_held_q <= 1'b0;
			x_negative_q <= 1'b0;
			y_negative_q <= 1'b0;
			pos_x_q      <= PosXInit;
			pos_y_q      <= PosYInit;
		end else if (accept) begin
			phase_q      <= phase_next;
			left_held_q  <= left_next;
			right_held_q <= right_next;
			x_negative_q <= x_negative_next;
			y_negative_q <= y_negative_next;
			pos_x_q      <= pos_x_next;
			pos_y_q      <= pos_y_next;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			left_button_q  <= left_next;
			right_button_q <= right_next;
			cursor_x_q     <= pos_x_ext[OutPosWidth-1:0];
			cursor_y_q     <= pos_y_ext[OutPosWidth-1:0];
			byte_phase_q   <= phase_out;
			packet_done_q  <= is_y;
		end
	end

	assign result_valid = result_valid_q;
	assign left_button  = left_button_q;
	assign right_button = right_button_q;
	assign cursor_x     = cursor_x_q;
	assign cursor_y     = cursor_y_q;
	assign byte_phase   = byte_phase_q;
	assign packet_done  = packet_done_q;

	// A completed packet is always reported on the y delta byte
	a_done_on_y: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (packet_done == (byte_phase == PhaseY)))
		else $error("packet_done disagrees with byte_phase");

	// A stalled result blocks new bytes
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !packet_ready)
		else $error("byte taken while result register is full");

	// The phase moves only on an accepted byte
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("packet phase moved without a byte");

	// A header byte is followed by the x delta
	a_header_then_x: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PhaseHeader) |=> (phase_q == PhaseX))
		else $error("header not followed by x delta phase");

endmodule

`default_nettype wire
